// ===== src/bgi_pkg.sv =====
`default_nettype none

package bgi_pkg;

    localparam int IDX_W      = 6;
    localparam int STEP_W     = 16;
    localparam int WGT_W      = 17;
    localparam int FRAC_W     = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int QUEUE_DEPTH = 4;

    // 1.0 in the weight format
    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_W;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(7282);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STEP_X = 1'b0,
        REG_STEP_Y = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        SIDE_BOTTOM = 2'd0,
        SIDE_TOP    = 2'd1,
        SIDE_LEFT   = 2'd2,
        SIDE_RIGHT  = 2'd3
    } side_t;

    // classified item as it travels from front to back
    typedef struct packed {
        op_t              op;
        side_t            side;
        logic [IDX_W-1:0] position;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic [WGT_W-1:0] ax;
        logic [WGT_W-1:0] ay;
    } job_t;

endpackage

`default_nettype wire

// ===== src/bgi_ram.sv =====
`default_nettype none

module bgi_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire logic [WIDTH-1:0]      wr_data,
    input  wire logic                  rd_en,
    input  wire logic [AW-1:0]         rd_addr,
    output logic      [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/bgi_queue.sv =====
`default_nettype none

module bgi_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] head_data,
    output logic                  empty,
    output logic                  full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign empty     = (count_reg == CW'(0));
    assign full      = (count_reg == CW'(DEPTH));
    assign head_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/bgi_front.sv =====
`default_nettype none

module bgi_front (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bgi_pkg::CFG_ADDR_W-1:0]   cfg_index,
    input  wire logic [bgi_pkg::STEP_W-1:0]       cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_operation,
    input  wire logic [1:0]                       s_side,
    input  wire logic [bgi_pkg::IDX_W-1:0]        s_position,
    input  wire logic [bgi_pkg::IDX_W-1:0]        s_col,
    input  wire logic [bgi_pkg::IDX_W-1:0]        s_row,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output bgi_pkg::job_t                         q_job
);

    localparam int PROD_W = bgi_pkg::IDX_W + bgi_pkg::STEP_W;

    logic [bgi_pkg::STEP_W-1:0] step_x_reg;
    logic [bgi_pkg::STEP_W-1:0] step_y_reg;
    logic [PROD_W-1:0]          prod_x;
    logic [PROD_W-1:0]          prod_y;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_x_reg <= bgi_pkg::STEP_RESET;
            step_y_reg <= bgi_pkg::STEP_RESET;
        end else if (cfg_valid) begin
            case (bgi_pkg::cfg_reg_t'(cfg_index))
                bgi_pkg::REG_STEP_X: step_x_reg <= cfg_data;
                bgi_pkg::REG_STEP_Y: step_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // weights saturate at 1.0
    assign prod_x = PROD_W'(s_col) * PROD_W'(step_x_reg);
    assign prod_y = PROD_W'(s_row) * PROD_W'(step_y_reg);

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_job          = '0;
        q_job.op       = bgi_pkg::op_t'(s_operation);
        q_job.side     = bgi_pkg::side_t'(s_side);
        q_job.position = s_position;
        q_job.col      = s_col;
        q_job.row      = s_row;
        if (q_job.op == bgi_pkg::OP_QUERY) begin
            q_job.ax = (prod_x > PROD_W'(bgi_pkg::WGT_ONE)) ? bgi_pkg::WGT_ONE
                                                            : prod_x[bgi_pkg::WGT_W-1:0];
            q_job.ay = (prod_y > PROD_W'(bgi_pkg::WGT_ONE)) ? bgi_pkg::WGT_ONE
                                                            : prod_y[bgi_pkg::WGT_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== src/bgi_back.sv =====
`default_nettype none

module bgi_back #(
    parameter int MAX_SIDE   = 64,
    parameter int COORD_BITS = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_empty,
    input  bgi_pkg::job_t                     q_job,
    input  wire logic [3*COORD_BITS-1:0]      q_coords,
    output logic                              q_pop,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [bgi_pkg::IDX_W-1:0]         m_out_col,
    output logic [bgi_pkg::IDX_W-1:0]         m_out_row,
    output logic signed [COORD_BITS-1:0]      m_point_x,
    output logic signed [COORD_BITS-1:0]      m_point_y,
    output logic signed [COORD_BITS-1:0]      m_point_z
);

    localparam int C  = COORD_BITS;
    localparam int IW = bgi_pkg::IDX_W;
    localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int DW = C + 1;
    localparam int BW = C + 2;
    localparam int PW = bgi_pkg::WGT_W + 1 + DW;
    localparam int SW = C + 21;
    localparam int RW = 3 * C;

    logic adv;
    logic load_go;
    logic query_go;
    logic pos_ok;

    logic [IW+AW-1:0] pos_ext, col_ext, row_ext;
    logic [AW-1:0]    pos_addr, col_addr, row_addr;

    logic we_bottom, we_top, we_left, we_right;
    logic [RW-1:0] rd_bottom, rd_top, rd_left, rd_right;

    // stage 1: edge reads in flight
    logic                      s1_valid_reg;
    logic [IW-1:0]             s1_col_reg, s1_row_reg;
    logic [bgi_pkg::WGT_W-1:0] s1_ax_reg, s1_ay_reg;
    logic                      s1_col_ok_reg, s1_row_ok_reg;

    // stage 2: differences
    logic                      s2_valid_reg;
    logic [IW-1:0]             s2_col_reg, s2_row_reg;
    logic [bgi_pkg::WGT_W-1:0] s2_ax_reg, s2_ay_reg;

    // stage 3: products
    logic          s3_valid_reg;
    logic [IW-1:0] s3_col_reg, s3_row_reg;

    logic                  m_valid_reg;
    logic [IW-1:0]         m_col_reg, m_row_reg;
    logic signed [C-1:0]   res [3];
    logic signed [C-1:0]   m_point_reg [3];

    assign adv      = !m_valid_reg || m_ready;
    assign q_pop    = adv && !q_empty;
    assign load_go  = q_pop && (q_job.op == bgi_pkg::OP_LOAD);
    assign query_go = q_pop && (q_job.op == bgi_pkg::OP_QUERY);

    assign pos_ok   = (32'(q_job.position) < 32'(MAX_SIDE));
    assign pos_ext  = {{AW{1'b0}}, q_job.position};
    assign col_ext  = {{AW{1'b0}}, q_job.col};
    assign row_ext  = {{AW{1'b0}}, q_job.row};
    assign pos_addr = pos_ext[AW-1:0];
    assign col_addr = col_ext[AW-1:0];
    assign row_addr = row_ext[AW-1:0];

    always_comb begin
        we_bottom = 1'b0;
        we_top    = 1'b0;
        we_left   = 1'b0;
        we_right  = 1'b0;
        if (load_go && pos_ok) begin
            case (q_job.side)
                bgi_pkg::SIDE_BOTTOM: we_bottom = 1'b1;
                bgi_pkg::SIDE_TOP:    we_top    = 1'b1;
                bgi_pkg::SIDE_LEFT:   we_left   = 1'b1;
                bgi_pkg::SIDE_RIGHT:  we_right  = 1'b1;
                default: ;
            endcase
        end
    end

    bgi_ram #(.WIDTH(RW), .DEPTH(MAX_SIDE)) u_bottom (
        .clk(aclk), .wr_en(we_bottom), .wr_addr(pos_addr), .wr_data(q_coords),
        .rd_en(query_go), .rd_addr(col_addr), .rd_data(rd_bottom)
    );

    bgi_ram #(.WIDTH(RW), .DEPTH(MAX_SIDE)) u_top (
        .clk(aclk), .wr_en(we_top), .wr_addr(pos_addr), .wr_data(q_coords),
        .rd_en(query_go), .rd_addr(col_addr), .rd_data(rd_top)
    );

    bgi_ram #(.WIDTH(RW), .DEPTH(MAX_SIDE)) u_left (
        .clk(aclk), .wr_en(we_left), .wr_addr(pos_addr), .wr_data(q_coords),
        .rd_en(query_go), .rd_addr(row_addr), .rd_data(rd_left)
    );

    bgi_ram #(.WIDTH(RW), .DEPTH(MAX_SIDE)) u_right (
        .clk(aclk), .wr_en(we_right), .wr_addr(pos_addr), .wr_data(q_coords),
        .rd_en(query_go), .rd_addr(row_addr), .rd_data(rd_right)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= query_go;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            m_valid_reg  <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_col_reg    <= q_job.col;
            s1_row_reg    <= q_job.row;
            s1_ax_reg     <= q_job.ax;
            s1_ay_reg     <= q_job.ay;
            s1_col_ok_reg <= (32'(q_job.col) < 32'(MAX_SIDE));
            s1_row_ok_reg <= (32'(q_job.row) < 32'(MAX_SIDE));
            s2_col_reg    <= s1_col_reg;
            s2_row_reg    <= s1_row_reg;
            s2_ax_reg     <= s1_ax_reg;
            s2_ay_reg     <= s1_ay_reg;
            s3_col_reg    <= s2_col_reg;
            s3_row_reg    <= s2_row_reg;
        end
        if (adv && s3_valid_reg) begin
            m_col_reg <= s3_col_reg;
            m_row_reg <= s3_row_reg;
            for (int k = 0; k < 3; k++) begin
                m_point_reg[k] <= res[k];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic signed [C-1:0]  e_bot, e_top, e_left, e_right;
        logic signed [DW-1:0] d1, d2;
        logic signed [C-1:0]  s2_a1_reg, s2_a2_reg;
        logic signed [DW-1:0] s2_d1_reg, s2_d2_reg;
        logic signed [PW-1:0] p1, p2;
        logic signed [BW-1:0] base;
        logic signed [PW-1:0] s3_p1_reg, s3_p2_reg;
        logic signed [BW-1:0] s3_base_reg;
        logic signed [SW-1:0] sum;

        // an index past the store reads as the origin
        assign e_bot   = s1_col_ok_reg ? rd_bottom[k*C +: C] : '0;
        assign e_top   = s1_col_ok_reg ? rd_top[k*C +: C]    : '0;
        assign e_left  = s1_row_ok_reg ? rd_left[k*C +: C]   : '0;
        assign e_right = s1_row_ok_reg ? rd_right[k*C +: C]  : '0;

        assign d1 = DW'(e_top) - DW'(e_bot);
        assign d2 = DW'(e_right) - DW'(e_left);

        // lerp(a,b,t) = a*2^16 + t*(b-a)
        assign p1 = $signed({1'b0, s2_ay_reg}) * s2_d1_reg;
        assign p2 = $signed({1'b0, s2_ax_reg}) * s2_d2_reg;
        // a1 + a2 + 1 carries the round-half-up offset once shifted
        assign base = BW'(s2_a1_reg) + BW'(s2_a2_reg) + BW'(1);

        assign sum    = (SW'(s3_base_reg) <<< bgi_pkg::FRAC_W) + SW'(s3_p1_reg) + SW'(s3_p2_reg);
        assign res[k] = sum[bgi_pkg::FRAC_W+1 +: C];

        always_ff @(posedge aclk) begin
            if (adv) begin
                s2_a1_reg   <= e_bot;
                s2_a2_reg   <= e_left;
                s2_d1_reg   <= d1;
                s2_d2_reg   <= d2;
                s3_p1_reg   <= p1;
                s3_p2_reg   <= p2;
                s3_base_reg <= base;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_out_col = m_col_reg;
    assign m_out_row = m_row_reg;
    assign m_point_x = m_point_reg[0];
    assign m_point_y = m_point_reg[1];
    assign m_point_z = m_point_reg[2];

endmodule

`default_nettype wire

// ===== src/boundary_grid_interpolator_core.sv =====
// pipeline: a query beat goes through the s1, s2, s3 and output registers after it is accepted
// (queue pop with edge read, difference, multiply, sum) before it shows on m_valid; a load beat
// writes its edge store when the queue pops it and returns nothing
// throughput: one beat per cycle while the back pipeline is not stalled; the queue hands one beat a cycle
// to the back pipeline, which stalls as a whole while m_valid is high and m_ready is low
// reset: synchronous active-low aresetn clears the queue and pipeline valids and sets the steps to 7282
`default_nettype none

module boundary_grid_interpolator_core #(
    parameter int MAX_SIDE   = 64,
    parameter int COORD_BITS = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bgi_pkg::CFG_ADDR_W-1:0]   cfg_index,
    input  wire logic [bgi_pkg::STEP_W-1:0]       cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_operation,
    input  wire logic [1:0]                       s_side,
    input  wire logic [bgi_pkg::IDX_W-1:0]        s_position,
    input  wire logic [bgi_pkg::IDX_W-1:0]        s_col,
    input  wire logic [bgi_pkg::IDX_W-1:0]        s_row,
    input  wire logic signed [COORD_BITS-1:0]     s_coord_x,
    input  wire logic signed [COORD_BITS-1:0]     s_coord_y,
    input  wire logic signed [COORD_BITS-1:0]     s_coord_z,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [bgi_pkg::IDX_W-1:0]             m_out_col,
    output logic [bgi_pkg::IDX_W-1:0]             m_out_row,
    output logic signed [COORD_BITS-1:0]          m_point_x,
    output logic signed [COORD_BITS-1:0]          m_point_y,
    output logic signed [COORD_BITS-1:0]          m_point_z
);

    // both steps go to 7282; edge stores keep their contents and must be loaded before use

    localparam int JW = $bits(bgi_pkg::job_t);
    localparam int QW = JW + 3 * COORD_BITS;

    logic          q_push, q_pop, q_empty, q_full;
    bgi_pkg::job_t push_job, head_job;
    logic [QW-1:0] push_data, head_data;

    bgi_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_side      (s_side),
        .s_position  (s_position),
        .s_col       (s_col),
        .s_row       (s_row),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    assign push_data = {push_job, s_coord_z, s_coord_y, s_coord_x};

    bgi_queue #(.WIDTH(QW), .DEPTH(bgi_pkg::QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .head_data (head_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign head_job = bgi_pkg::job_t'(head_data[QW-1 -: JW]);

    bgi_back #(.MAX_SIDE(MAX_SIDE), .COORD_BITS(COORD_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_job     (head_job),
        .q_coords  (head_data[3*COORD_BITS-1:0]),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_col (m_out_col),
        .m_out_row (m_out_row),
        .m_point_x (m_point_x),
        .m_point_y (m_point_y),
        .m_point_z (m_point_z)
    );

endmodule

`default_nettype wire
